@@ hdl/topt_pkg.sv @@
// Shared types and codes for the 3-opt tour move block.
// No dependencies; imported by every module of the block.
package topt_pkg;

   localparam logic [2:0] ACT_LOAD_DIST = 3'd0;
   localparam logic [2:0] ACT_LOAD_TOUR = 3'd1;
   localparam logic [2:0] ACT_SET_LEN   = 3'd2;
   localparam logic [2:0] ACT_MOVE      = 3'd3;
   localparam logic [2:0] ACT_READ      = 3'd4;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_NO_IMPR  = 2'd2;
   localparam logic [1:0] ST_IMPROVED = 2'd3;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  row_city;
      logic [7:0]  col_city;
      logic [23:0] dist_value;
      logic [7:0]  tour_pos;
      logic [7:0]  city_value;
      logic [31:0] length_value;
      logic [7:0]  cut_a;
      logic [7:0]  cut_b;
      logic [7:0]  cut_c;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  chosen_case;
      logic [25:0] gain;
      logic [31:0] tour_length;
      logic [7:0]  city_out;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LATCH, OP_EXEC, OP_TFETCH, OP_DFETCH,
      OP_BEST, OP_APPLY, OP_EMIT, OP_COPY, OP_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic done;      // current phase finished this cycle
      logic is_move;
      logic move_ok;
      logic improve;
   } sts_type;

endpackage

@@ hdl/three_opt_tour_move_top.sv @@
// 3-opt tour move. Loads, reads, unknown actions and rejected cuts go straight to the result;
// a valid move first fetches its tour entries and distances and picks the best case.
// One item in flight: the next transfer is taken only after the result is in the output
// register, and a waiting result adds its stall.
// Improving moves then run the rewrite: n entries into scratch, n back, one per cycle.
// Sync active-high reset: control, length 0, city_count 256; memories undefined until written.
module three_opt_tour_move_top import topt_pkg::*; #(
   parameter int MAX_CITIES = 256,
   parameter int DIST_BITS  = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data
);

   cmd_type cmd;   // controller to datapath
   sts_type sts;   // datapath to controller

   // sequencing and both handshakes
   topt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // memories, gain evaluation, tour rewrite
   topt_dp #(
      .MAX_CITIES (MAX_CITIES),
      .DIST_BITS  (DIST_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_data    (rsp_data)
   );

endmodule

@@ hdl/topt_ctrl.sv @@
// Controller FSM of the 3-opt tour move block: handshakes and phase sequencing.
// Depends on topt_pkg.
module topt_ctrl import topt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_TFETCH, S_DFETCH, S_BEST, S_APPLY, S_EMIT, S_COPY, S_RESP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      unique case (state_ff)
         S_IDLE:   cmd.op = req_valid ? OP_LATCH : OP_NONE;
         S_EXEC:   cmd.op = OP_EXEC;
         S_TFETCH: cmd.op = OP_TFETCH;
         S_DFETCH: cmd.op = OP_DFETCH;
         S_BEST:   cmd.op = OP_BEST;
         S_APPLY:  cmd.op = OP_APPLY;
         S_EMIT:   cmd.op = OP_EMIT;
         S_COPY:   cmd.op = OP_COPY;
         S_RESP:   cmd.op = slot_free ? OP_RESP : OP_NONE;
         default:  cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result replaces one that leaves in the same cycle
         if (state_ff == S_RESP && slot_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)                 rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE:   if (req_valid) state_ff <= S_EXEC;
            S_EXEC:   state_ff <= (sts.is_move && sts.move_ok) ? S_TFETCH : S_RESP;
            S_TFETCH: if (sts.done) state_ff <= S_DFETCH;
            S_DFETCH: if (sts.done) state_ff <= S_BEST;
            S_BEST:   if (sts.done) state_ff <= S_APPLY;
            S_APPLY:  state_ff <= sts.improve ? S_EMIT : S_RESP;
            S_EMIT:   if (sts.done) state_ff <= S_COPY;
            S_COPY:   if (sts.done) state_ff <= S_RESP;
            S_RESP:   if (slot_free) state_ff <= S_IDLE;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff)
      else $error("result dropped while stalled");
   a_exec_after_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |-> $past(state_ff) == S_IDLE)
      else $error("exec not entered from idle");
   a_emit_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && $past(state_ff) != S_EMIT |-> $past(state_ff) == S_APPLY)
      else $error("tour rewrite started without an improving move");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_LATCH |-> state_ff == S_IDLE && !req_stall)
      else $error("item latched outside idle");

endmodule

@@ hdl/topt_dp.sv @@
// Datapath of the 3-opt tour move block: memories, gain arithmetic, tour rewrite.
// Depends on topt_pkg; sequenced by topt_ctrl.
module topt_dp import topt_pkg::*; #(
   parameter int MAX_CITIES = 256,
   parameter int DIST_BITS  = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data,
   input  cmd_type    cmd,
   output sts_type    sts,
   output rsp_type    rsp_data
);

   localparam int PW  = $clog2(MAX_CITIES);
   localparam int NW  = $clog2(MAX_CITIES + 1);
   localparam int KW  = (NW > 5) ? NW : 5;
   localparam int XW  = ((PW > 8) ? PW : 8) + 2;
   localparam int DAW = $clog2(MAX_CITIES * MAX_CITIES);
   localparam int GW  = DIST_BITS + 3;
   localparam int LW  = ((GW > 32) ? GW : 32) + 1;

   // bit0 S1 reversed, bit1 S2, bit2 S3
   localparam logic [2:0] REV_MASK [8] = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd3, 3'd2, 3'd6, 3'd7};
   // distance fetch list over cities A..F (0..5)
   localparam logic [2:0] PAIR_R [16] = '{3'd0, 3'd2, 3'd4, 3'd1, 3'd0, 3'd3, 3'd2, 3'd0,
                                         3'd4, 3'd2, 3'd1, 3'd4, 3'd1, 3'd3, 3'd2, 3'd1};
   localparam logic [2:0] PAIR_C [16] = '{3'd1, 3'd3, 3'd5, 3'd5, 3'd4, 3'd5, 3'd4, 3'd3,
                                         3'd2, 3'd5, 3'd3, 3'd0, 3'd0, 3'd2, 3'd0, 3'd4};

   logic [7:0]           tour_mem [MAX_CITIES];
   logic [7:0]           scr_mem  [MAX_CITIES];
   logic [DIST_BITS-1:0] dist_mem [MAX_CITIES * MAX_CITIES];

   req_type              req_ff;
   rsp_type              rsp_ff;
   logic [8:0]           csr_ff;
   logic [31:0]          len_ff;
   logic [7:0]           city_ff [6];
   logic [DIST_BITS-1:0] d_ff [16];
   logic signed [GW-1:0] best_ff;
   logic [2:0]           chosen_ff;
   logic [1:0]           code_ff;
   logic [KW-1:0]        cnt_ff;
   logic [7:0]           tour_rd_ff;
   logic [7:0]           scr_rd_ff;
   logic [DIST_BITS-1:0] dist_rd_ff;
   logic                 dvld_ff;

   // decoded request
   logic [XW-1:0] n_x, a_x, b_x, c_x, k_x, f_x, pos_x, row_x, col_x;
   logic          move_ok, pos_ok, rc_ok;

   assign n_x   = (XW'(csr_ff) > XW'(MAX_CITIES)) ? XW'(MAX_CITIES) : XW'(csr_ff);
   assign a_x   = XW'(req_ff.cut_a);
   assign b_x   = XW'(req_ff.cut_b);
   assign c_x   = XW'(req_ff.cut_c);
   assign f_x   = (c_x + 1'b1 == n_x) ? '0 : c_x + 1'b1;
   assign k_x   = XW'(cnt_ff);
   assign pos_x = XW'(req_ff.tour_pos);
   assign row_x = XW'(req_ff.row_city);
   assign col_x = XW'(req_ff.col_city);
   assign pos_ok = pos_x < XW'(MAX_CITIES);
   assign rc_ok  = (row_x < XW'(MAX_CITIES)) && (col_x < XW'(MAX_CITIES));
   assign move_ok = (a_x < b_x) && (b_x < c_x) && (c_x < n_x) && (b_x - a_x >= XW'(2))
                    && (c_x - b_x >= XW'(2)) && (n_x - (c_x - a_x) >= XW'(2));

   // tour fetch position list
   logic [XW-1:0] tf_pos;
   always_comb begin
      unique case (cnt_ff[2:0])
         3'd0:    tf_pos = a_x;
         3'd1:    tf_pos = a_x + 1'b1;
         3'd2:    tf_pos = b_x;
         3'd3:    tf_pos = b_x + 1'b1;
         3'd4:    tf_pos = c_x;
         default: tf_pos = f_x;
      endcase
   end

   // segment walk for the rewrite
   logic [XW-1:0] l1_x, l2_x, seg_start, seg_len, seg_i, raw_x, idx_x;
   logic [2:0]    mask;
   logic          seg_rev;
   assign mask = REV_MASK[chosen_ff];
   assign l1_x = n_x - c_x + a_x;
   assign l2_x = b_x - a_x;
   always_comb begin
      priority if (k_x < l1_x) begin
         seg_start = c_x + 1'b1;
         seg_len   = l1_x;
         seg_i     = k_x;
         seg_rev   = mask[0];
      end else if (k_x < l1_x + l2_x) begin
         seg_start = a_x + 1'b1;
         seg_len   = l2_x;
         seg_i     = k_x - l1_x;
         seg_rev   = mask[1];
      end else begin
         seg_start = b_x + 1'b1;
         seg_len   = c_x - b_x;
         seg_i     = k_x - l1_x - l2_x;
         seg_rev   = mask[2];
      end
   end
   assign raw_x = seg_rev ? seg_start + seg_len - 1'b1 - seg_i : seg_start + seg_i;
   assign idx_x = (raw_x >= n_x) ? raw_x - n_x : raw_x;

   // gains
   logic signed [GW-1:0] ds [16];
   logic signed [GW-1:0] g  [8];
   logic signed [GW-1:0] s3;
   always_comb begin
      for (int j = 0; j < 16; j++) ds[j] = signed'({3'b000, d_ff[j]});
   end
   assign s3   = ds[0] + ds[1] + ds[2];
   assign g[0] = '0;
   assign g[1] = ds[0] + ds[2] - ds[3] - ds[4];
   assign g[2] = ds[1] + ds[2] - ds[5] - ds[6];
   assign g[3] = s3 - ds[7] - ds[3] - ds[8];
   assign g[4] = s3 - ds[9] - ds[10] - ds[11];
   assign g[5] = ds[12] + ds[13] - ds[14] - ds[10];
   assign g[6] = s3 - ds[15] - ds[5] - ds[14];
   assign g[7] = s3 - ds[7] - ds[9] - ds[15];

   // length update
   logic [LW-1:0] best_x, len_x, len_sub;
   logic          improve;
   assign improve = (best_ff > 0);
   assign best_x  = {{(LW-GW){1'b0}}, best_ff};
   assign len_x   = {{(LW-32){1'b0}}, len_ff};
   assign len_sub = (best_x >= len_x) ? '0 : len_x - best_x;

   // phase completion
   logic done;
   always_comb begin
      unique case (cmd.op)
         OP_TFETCH: done = (cnt_ff == KW'(6));
         OP_DFETCH: done = (cnt_ff == KW'(16));
         OP_BEST:   done = (cnt_ff == KW'(7));
         OP_EMIT,
         OP_COPY:   done = (k_x == n_x);
         default:   done = 1'b0;
      endcase
   end

   assign sts.done    = done;
   assign sts.is_move = (req_ff.action == ACT_MOVE);
   assign sts.move_ok = move_ok;
   assign sts.improve = improve;
   assign rsp_data    = rsp_ff;

   // memory port selection
   logic [PW-1:0]  tour_ra, tour_wa, scr_wa, dist_pr, dist_pc;
   logic [7:0]     tour_wd, dist_rc, dist_cc;
   logic           tour_we;
   logic [DAW-1:0] dist_ra, dist_wa;
   logic [DIST_BITS+23:0] dval_x;

   assign dval_x = {{DIST_BITS{1'b0}}, req_ff.dist_value};
   assign dist_rc = city_ff[PAIR_R[cnt_ff[3:0]]];
   assign dist_cc = city_ff[PAIR_C[cnt_ff[3:0]]];
   assign dist_pr = PW'(dist_rc);
   assign dist_pc = PW'(dist_cc);
   assign dist_ra = DAW'(dist_pr) * DAW'(MAX_CITIES) + DAW'(dist_pc);
   assign dist_wa = DAW'(row_x[PW-1:0]) * DAW'(MAX_CITIES) + DAW'(col_x[PW-1:0]);
   assign scr_wa  = PW'(cnt_ff - 1'b1);

   always_comb begin
      unique case (cmd.op)
         OP_TFETCH: tour_ra = tf_pos[PW-1:0];
         OP_EMIT:   tour_ra = idx_x[PW-1:0];
         default:   tour_ra = pos_x[PW-1:0];
      endcase
      if (cmd.op == OP_COPY) begin
         tour_we = (cnt_ff != '0);
         tour_wa = scr_wa;
         tour_wd = scr_rd_ff;
      end else begin
         tour_we = (cmd.op == OP_EXEC) && (req_ff.action == ACT_LOAD_TOUR) && pos_ok;
         tour_wa = pos_x[PW-1:0];
         tour_wd = req_ff.city_value;
      end
   end

   always_ff @(posedge clock) begin
      if (tour_we) tour_mem[tour_wa] <= tour_wd;
      tour_rd_ff <= tour_mem[tour_ra];
      if (cmd.op == OP_EMIT && cnt_ff != '0) scr_mem[scr_wa] <= tour_rd_ff;
      scr_rd_ff <= scr_mem[cnt_ff[PW-1:0]];
      if (cmd.op == OP_EXEC && req_ff.action == ACT_LOAD_DIST && rc_ok)
         dist_mem[dist_wa] <= dval_x[DIST_BITS-1:0];
      dist_rd_ff <= dist_mem[dist_ra];
      dvld_ff    <= (XW'(dist_rc) < XW'(MAX_CITIES)) && (XW'(dist_cc) < XW'(MAX_CITIES));
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= 9'd256;
         len_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (csr_wr_en) csr_ff <= csr_wr_data;
         if (done || cmd.op == OP_NONE || cmd.op == OP_LATCH || cmd.op == OP_EXEC
             || cmd.op == OP_APPLY || cmd.op == OP_RESP)
            cnt_ff <= '0;
         else
            cnt_ff <= cnt_ff + 1'b1;
         if (cmd.op == OP_EXEC && req_ff.action == ACT_SET_LEN) len_ff <= req_ff.length_value;
         if (cmd.op == OP_APPLY && improve) len_ff <= len_sub[31:0];
      end
   end

   // payload registers
   logic [GW+25:0] gain_x;
   assign gain_x = {26'd0, best_ff};

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LATCH: req_ff <= req_data;
         OP_EXEC: begin
            best_ff   <= '0;
            chosen_ff <= '0;
            code_ff   <= (req_ff.action == ACT_MOVE && !move_ok) ? ST_INVALID : ST_DONE;
         end
         OP_TFETCH: if (cnt_ff != '0) city_ff[cnt_ff[2:0] - 3'd1] <= tour_rd_ff;
         OP_DFETCH: if (cnt_ff != '0) d_ff[4'(cnt_ff - 1'b1)] <= dvld_ff ? dist_rd_ff : '0;
         OP_BEST: begin
            if (cnt_ff != '0 && g[cnt_ff[2:0]] > best_ff) begin
               best_ff   <= g[cnt_ff[2:0]];
               chosen_ff <= cnt_ff[2:0];
            end
         end
         OP_APPLY: begin
            code_ff <= improve ? ST_IMPROVED : ST_NO_IMPR;
            if (!improve) chosen_ff <= '0;
         end
         OP_RESP: begin
            rsp_ff.status      <= code_ff;
            rsp_ff.chosen_case <= chosen_ff;
            rsp_ff.gain        <= gain_x[25:0];
            rsp_ff.tour_length <= len_ff;
            rsp_ff.city_out    <= (req_ff.action == ACT_READ && pos_ok) ? tour_rd_ff : 8'd0;
         end
         default: ;
      endcase
   end

endmodule

@@ dv/tb_three_opt_tour_move_top.sv @@
// Self-checking testbench for three_opt_tour_move_top: loads, reads and 3-opt moves.
// Depends on topt_pkg (hdl/topt_pkg.sv) and the block's RTL; nothing else.
`timescale 1ns / 100ps

module tb_three_opt_tour_move_top;
   import topt_pkg::*;

   localparam int  NCITY      = 256;
   localparam int  CYCLE_CAP  = 3000000;
   localparam int  SETTLE_CYC = 40;
   // which segments each reconnection reverses: bit0 S1, bit1 S2, bit2 S3
   localparam logic [2:0] SEG_FLIP [8] = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd3, 3'd2, 3'd6, 3'd7};

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_wr_en;
   logic [8:0] csr_wr_data;

   three_opt_tour_move_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ---------------------------------------------------------------------
   // Shadow copy of the block state
   // ---------------------------------------------------------------------
   logic [23:0] dist_mem [NCITY*NCITY];
   logic [7:0]  tour_mem [NCITY];
   logic [7:0]  tour_tmp [NCITY];
   logic [31:0] len_total;
   logic [8:0]  city_cnt;

   rsp_type     pending_rsp [$];   // expected results, oldest first
   int          err_cnt;
   int          cycle_cnt;
   int          xfer_in, xfer_out, moves_taken, moves_bad;
   bit          idle_on;           // random gaps/stalls enabled
   bit          quiet;             // final stretch: no idling at all
   int          stall_left;

   function automatic int cities_in_use();
      return (city_cnt > NCITY) ? NCITY : int'(city_cnt);
   endfunction

   function automatic longint dist_of(logic [7:0] r, logic [7:0] c);
      return longint'(dist_mem[{r, c}]);
   endfunction

   // copy one segment of the current tour into the scratch order
   task automatic put_segment(int start, int len, bit flip, int n, inout int k);
      int idx;
      for (int i = 0; i < len; i++) begin
         idx = flip ? start + len - 1 - i : start + i;
         while (idx >= n) idx -= n;
         if (k < NCITY) tour_tmp[k] = tour_mem[idx];
         k++;
      end
   endtask

   // expected result of one accepted transfer; updates the shadow state
   task automatic tour_step(input req_type r, output rsp_type o);
      int          n, a, b, c, k;
      logic [7:0]  ca, cb, cc, cd, ce, cf;
      longint      ab, cdd, ef, best;
      longint      g [8];
      logic [2:0]  pick, flip;
      o = '0;
      case (r.action)
         ACT_LOAD_DIST: dist_mem[{r.row_city, r.col_city}] = r.dist_value;
         ACT_LOAD_TOUR: tour_mem[r.tour_pos] = r.city_value;
         ACT_SET_LEN:   len_total = r.length_value;
         ACT_READ:      o.city_out = tour_mem[r.tour_pos];
         ACT_MOVE: begin
            n = cities_in_use();
            a = r.cut_a; b = r.cut_b; c = r.cut_c;
            if (!(a < b && b < c && c < n && b - a >= 2 && c - b >= 2 && n - (c - a) >= 2)) begin
               o.status = ST_INVALID;
               moves_bad++;
            end else begin
               ca = tour_mem[a]; cb = tour_mem[a+1];
               cc = tour_mem[b]; cd = tour_mem[b+1];
               ce = tour_mem[c]; cf = tour_mem[(c + 1 == n) ? 0 : c + 1];
               ab = dist_of(ca, cb); cdd = dist_of(cc, cd); ef = dist_of(ce, cf);
               g[0] = 0;
               g[1] = ab + ef - dist_of(cb, cf) - dist_of(ca, ce);
               g[2] = cdd + ef - dist_of(cd, cf) - dist_of(cc, ce);
               g[3] = ab + cdd + ef - dist_of(ca, cd) - dist_of(cb, cf) - dist_of(ce, cc);
               g[4] = ab + cdd + ef - dist_of(cc, cf) - dist_of(cb, cd) - dist_of(ce, ca);
               g[5] = dist_of(cb, ca) + dist_of(cd, cc) - dist_of(cc, ca) - dist_of(cb, cd);
               g[6] = ab + cdd + ef - dist_of(cb, ce) - dist_of(cd, cf) - dist_of(cc, ca);
               g[7] = ab + cdd + ef - dist_of(ca, cd) - dist_of(cc, cf) - dist_of(cb, ce);
               best = 0; pick = 0;
               for (int i = 1; i < 8; i++)
                  if (g[i] > best) begin
                     best = g[i]; pick = 3'(i);
                  end
               o.gain = best[25:0];
               if (best > 0) begin
                  o.status = ST_IMPROVED;
                  o.chosen_case = pick;
                  moves_taken++;
                  // length saturates at zero when the gain exceeds it
                  if (best >= longint'(len_total)) len_total = '0;
                  else len_total = len_total - best[31:0];
                  flip = SEG_FLIP[pick];
                  k = 0;
                  put_segment(c + 1, n - c + a, flip[0], n, k);
                  put_segment(a + 1, b - a, flip[1], n, k);
                  put_segment(b + 1, c - b, flip[2], n, k);
                  for (int i = 0; i < n; i++) tour_mem[i] = tour_tmp[i];
               end else begin
                  o.status = ST_NO_IMPR;
               end
            end
         end
         default: ;   // unknown actions: no effect
      endcase
      o.tour_length = len_total;
   endtask

   // ---------------------------------------------------------------------
   // Clock, reset, cycle limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_CAP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Result side: random stall bursts, compare at the rising edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset || quiet || !idle_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         xfer_out++;
         if (pending_rsp.size() == 0) begin
            $error("result transfer with nothing expected: %h", rsp_data);
            err_cnt++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status exp %0d got %0d", want.status, rsp_data.status); err_cnt++;
            end
            if (rsp_data.chosen_case !== want.chosen_case) begin
               $error("chosen_case exp %0d got %0d", want.chosen_case, rsp_data.chosen_case);
               err_cnt++;
            end
            if (rsp_data.gain !== want.gain) begin
               $error("gain exp %0d got %0d", want.gain, rsp_data.gain); err_cnt++;
            end
            if (rsp_data.tour_length !== want.tour_length) begin
               $error("tour_length exp %0d got %0d", want.tour_length, rsp_data.tour_length);
               err_cnt++;
            end
            if (rsp_data.city_out !== want.city_out) begin
               $error("city_out exp %0d got %0d", want.city_out, rsp_data.city_out); err_cnt++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   function automatic req_type rand_req();
      logic [127:0] bits;
      bits = {$urandom(), $urandom(), $urandom(), $urandom()};
      return req_type'(bits[$bits(req_type)-1:0]);
   endfunction

   // one transfer; typed=1 queues the table's value instead of the prediction
   task automatic send(req_type r, bit typed = 0, rsp_type typed_rsp = '0);
      rsp_type o;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      xfer_in++;
      tour_step(r, o);
      pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : o);
      // sender gap burst
      if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 11)) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // register write only with the block idle
   task automatic set_cities(int v);
      drain();
      repeat (SETTLE_CYC) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= 9'(v);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      city_cnt = 9'(v);
   endtask

   // ---------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   dir_row_type dir_rows [$];

   function automatic void add_row(dir_row_type d);
      dir_rows.insert(dir_rows.size(), d);
   endfunction

   // x/y/v mean row/col/dist, pos/city, -/-/length or cut a/b/c by action
   function automatic dir_row_type drow(logic [2:0] act, int x, int y, longint v, bit typed,
                                        logic [1:0] st, logic [31:0] len, logic [7:0] cout);
      dir_row_type d;
      d.item = rand_req();
      d.item.action = act;
      case (act)
         ACT_LOAD_DIST: begin
            d.item.row_city = 8'(x); d.item.col_city = 8'(y); d.item.dist_value = 24'(v);
         end
         ACT_LOAD_TOUR: begin d.item.tour_pos = 8'(x); d.item.city_value = 8'(y); end
         ACT_SET_LEN:   d.item.length_value = 32'(v);
         ACT_MOVE: begin d.item.cut_a = 8'(x); d.item.cut_b = 8'(y); d.item.cut_c = 8'(v); end
         ACT_READ:      d.item.tour_pos = 8'(x);
         default: ;
      endcase
      d.typed = typed;
      d.want = '0;
      d.want.status = st;
      d.want.tour_length = len;
      d.want.city_out = cout;
      return d;
   endfunction

   // ---------------------------------------------------------------------
   // Random phase: fresh tour over a small city pool, its matrix, then a mix
   // ---------------------------------------------------------------------
   task automatic run_phase(int cfg, int pool_sz, int count, bit hold_mid);
      logic [7:0] pool [8];
      req_type    r;
      int         n, pick, a, b, c, cmax;
      set_cities(cfg);
      n = cities_in_use();
      for (int i = 0; i < pool_sz; i++) pool[i] = 8'($urandom_range(0, 255));
      // every matrix cell a move can touch is written before any move
      for (int i = 0; i < pool_sz; i++)
         for (int j = 0; j < pool_sz; j++) begin
            r = rand_req();
            r.action = ACT_LOAD_DIST;
            r.row_city = pool[i]; r.col_city = pool[j];
            if ($urandom_range(0, 9) != 0) r.dist_value = 24'($urandom_range(0, 2000));
            send(r);
         end
      for (int p = 0; p < n; p++) begin
         r = rand_req();
         r.action = ACT_LOAD_TOUR;
         r.tour_pos = 8'(p);
         r.city_value = pool[$urandom_range(0, pool_sz - 1)];
         send(r);
      end
      r = rand_req();
      r.action = ACT_SET_LEN;
      send(r);
      for (int it = 0; it < count; it++) begin
         if (hold_mid && it == count / 2) drain();   // sender waits for every result
         r = rand_req();
         pick = $urandom_range(0, 99);
         if (pick < 62 && n >= 6) begin
            // well-formed cuts: every segment two or more entries
            r.action = ACT_MOVE;
            a = $urandom_range(0, n - 5);
            cmax = (a == 0) ? n - 2 : n - 1;
            if (cmax < a + 4) begin a = 1; cmax = n - 1; end
            b = $urandom_range(a + 2, cmax - 2);
            c = $urandom_range(b + 2, cmax);
            r.cut_a = 8'(a); r.cut_b = 8'(b); r.cut_c = 8'(c);
         end else if (pick < 72) begin
            r.action = ACT_MOVE;   // random cuts, mostly rejected
         end else if (pick < 80) begin
            r.action = ACT_READ;
            r.tour_pos = ($urandom_range(0, 15) == 0) ? 8'd255 : 8'($urandom_range(0, n - 1));
         end else if (pick < 87) begin
            r.action = ACT_LOAD_DIST;
            r.row_city = pool[$urandom_range(0, pool_sz - 1)];
            r.col_city = pool[$urandom_range(0, pool_sz - 1)];
            if ($urandom_range(0, 3) != 0) r.dist_value = 24'($urandom_range(0, 2000));
         end else if (pick < 92) begin
            r.action = ACT_LOAD_TOUR;
            r.tour_pos = 8'($urandom_range(0, n - 1));
            r.city_value = pool[$urandom_range(0, pool_sz - 1)];
         end else if (pick < 95) begin
            r.action = ACT_SET_LEN;
            // small lengths exercise the saturating subtract
            if ($urandom_range(0, 1) == 0) r.length_value = $urandom_range(0, 300);
         end else if (pick < 97) begin
            r.action = ACT_LOAD_DIST;   // anywhere in the matrix
         end else begin
            r.action = 3'($urandom_range(5, 7));
         end
         send(r);
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      err_cnt = 0; cycle_cnt = 0; stall_left = 0;
      xfer_in = 0; xfer_out = 0; moves_taken = 0; moves_bad = 0;
      idle_on = 1'b1; quiet = 1'b0;
      len_total = '0;
      city_cnt  = 9'd256;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // after reset: 256 cities, length 0
      add_row(drow(ACT_SET_LEN, 0, 0, 32'hFFFF_FFFF, 1, ST_DONE, 32'hFFFF_FFFF, 0));
      add_row(drow(ACT_LOAD_DIST, 255, 255, 24'hFF_FFFF, 1, ST_DONE, 32'hFFFF_FFFF, 0));
      add_row(drow(ACT_LOAD_DIST, 0, 0, 0, 1, ST_DONE, 32'hFFFF_FFFF, 0));
      add_row(drow(ACT_LOAD_TOUR, 255, 255, 0, 1, ST_DONE, 32'hFFFF_FFFF, 0));
      add_row(drow(ACT_READ, 255, 0, 0, 1, ST_DONE, 32'hFFFF_FFFF, 8'd255));
      add_row(drow(ACT_LOAD_TOUR, 0, 0, 0, 1, ST_DONE, 32'hFFFF_FFFF, 0));
      add_row(drow(ACT_READ, 0, 0, 0, 1, ST_DONE, 32'hFFFF_FFFF, 0));
      // rejected cuts: all equal, unsorted, adjacent, wrap segment too short
      add_row(drow(ACT_MOVE, 0, 0, 0, 1, ST_INVALID, 32'hFFFF_FFFF, 0));
      add_row(drow(ACT_MOVE, 9, 5, 1, 1, ST_INVALID, 32'hFFFF_FFFF, 0));
      add_row(drow(ACT_MOVE, 0, 1, 10, 1, ST_INVALID, 32'hFFFF_FFFF, 0));
      add_row(drow(ACT_MOVE, 0, 100, 255, 1, ST_INVALID, 32'hFFFF_FFFF, 0));
      add_row(drow(ACT_MOVE, 255, 255, 255, 1, ST_INVALID, 32'hFFFF_FFFF, 0));
      // unknown actions do nothing
      add_row(drow(3'd5, 0, 0, 0, 1, ST_DONE, 32'hFFFF_FFFF, 0));
      add_row(drow(3'd6, 0, 0, 0, 1, ST_DONE, 32'hFFFF_FFFF, 0));
      add_row(drow(3'd7, 0, 0, 0, 1, ST_DONE, 32'hFFFF_FFFF, 0));
      add_row(drow(ACT_SET_LEN, 0, 0, 0, 1, ST_DONE, 0, 0));
      add_row(drow(ACT_READ, 255, 0, 0, 0, ST_DONE, 0, 0));
      foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

      // cfg, city pool, mixed transfers, mid-phase hold
      run_phase(6,   4, 120, 1);
      idle_on = 1'b0;                 // a stretch with no idling
      run_phase(5,   3, 30,  0);
      idle_on = 1'b1;
      run_phase(511, 6, 40,  0);      // above range: acts as 256
      run_phase(7,   5, 120, 0);
      idle_on = 1'b0;
      run_phase(12,  8, 100, 0);
      idle_on = 1'b1;
      run_phase(20,  8, 60,  0);
      run_phase(9,   2, 40,  0);
      quiet = 1'b1;                   // last part runs flat out
      run_phase(6,   8, 40,  0);

      drain();
      repeat (SETTLE_CYC) @(posedge clock);
      $display("Covered %0d request / %0d result transfers: %0d improving moves, %0d rejected cuts,",
               xfer_in, xfer_out, moves_taken, moves_bad);
      $display("city counts 5..20, 256 and an over-range write, with random stalls and gaps.");
      if (err_cnt == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
